### rtl/lfu_pkg.sv
package lfu_pkg;

    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W  = $clog2(CAPACITY + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data_in;
    } lfu_req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] data_out;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } lfu_rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_BITS-1:0]    count;
    } lfu_entry_t;

    localparam int ENTRY_W = $bits(lfu_entry_t);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WRITE = 4'b1000
    } lfu_state_t;

endpackage

### rtl/lfu_cache_table_unit.sv
// LFU key/value cache with up to CAPACITY entries.
// Request channel: drive req (mode, key, data_in) and raise start; the item
// is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with rsp (hit, data_out,
// evicted, evicted_key) valid in that cycle; the receiver cannot stall it,
// so results must be captured when done is seen.
// Config channel: cfg_data is the allowed entry count, written at an edge
// where cfg_valid and cfg_ready are high; cfg_ready is high while idle.
// Each item scans the entry RAM once, one entry per cycle through its single
// read port, then waits in a drain state for the last read and decides and
// writes back in a write state. done is registered from the write state, and
// the result is taken at the edge after done rises.
// A new item may be accepted in the write-back cycle, so back-to-back items
// need no idle state between them.
// Reset clears all valid bits and sets the entry limit to 16; the cache
// starts empty and no clearing pass is needed.
module lfu_cache_table_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lfu_pkg::lfu_req_t          req,
    output logic                       done,
    output lfu_pkg::lfu_rsp_t          rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lfu_pkg::CFG_W-1:0]  cfg_data
);
    import lfu_pkg::*;

    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(CAPACITY - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    lfu_state_t             state_reg, state_next;
    logic [CFG_W-1:0]       limit_reg;
    lfu_req_t               req_q_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   cmp_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;

    logic                   found_reg;
    logic [IDX_W-1:0]       found_idx_reg;
    logic [IDX_W-1:0]       found_rank_reg;
    logic signed [DATA_W-1:0] found_val_reg;
    logic [COUNT_BITS-1:0]  found_cnt_reg;

    logic                   vic_reg;
    logic [IDX_W-1:0]       vic_idx_reg;
    logic [IDX_W-1:0]       vic_rank_reg;
    logic [COUNT_BITS-1:0]  vic_cnt_reg;
    logic signed [KEY_W-1:0] vic_key_reg;

    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [OCC_W-1:0]       occ_reg;

    logic [CAPACITY-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]       rank_reg  [CAPACITY];
    logic [IDX_W-1:0]       rank_next [CAPACITY];

    logic                   done_reg;
    lfu_rsp_t               rsp_reg;

    logic                   accept;
    logic [ENTRY_W-1:0]     rd_bits;
    lfu_entry_t             rd_entry;
    logic                   cur_valid;
    logic [IDX_W-1:0]       cur_rank;
    logic                   is_match, is_vic, is_free;

    logic                   is_get, limit_zero, full;
    logic                   do_bump, do_insert, do_evict, wr_en;
    logic [IDX_W-1:0]       tgt_idx;
    lfu_entry_t             wr_entry;
    lfu_rsp_t               rsp_next;

    assign busy      = (state_reg != ST_IDLE) && (state_reg != ST_WRITE);
    assign accept    = start && !busy;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tgt_idx),
        .wr_data (wr_entry),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (idx_reg),
        .rd_data (rd_bits)
    );

    assign rd_entry  = lfu_entry_t'(rd_bits);
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_rank  = rank_reg[cmp_idx_reg];

    assign is_match = cmp_vld_reg && cur_valid && !found_reg && (rd_entry.key == req_q_reg.key);
    assign is_vic   = cmp_vld_reg && cur_valid &&
                      (!vic_reg || (rd_entry.count < vic_cnt_reg) ||
                       ((rd_entry.count == vic_cnt_reg) && (cur_rank > vic_rank_reg)));
    assign is_free  = cmp_vld_reg && !cur_valid && !free_found_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = accept ? ST_SCAN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // decide and write back
    always_comb
    begin
        is_get     = (req_q_reg.mode == MODE_GET);
        limit_zero = (limit_reg == '0);
        full       = (32'(occ_reg) >= 32'(limit_reg)) || (32'(occ_reg) >= 32'(CAPACITY));
        do_bump    = found_reg && (is_get || !limit_zero);
        do_insert  = !found_reg && !is_get && !limit_zero;
        do_evict   = do_insert && full;
        wr_en      = (state_reg == ST_WRITE) && (do_bump || do_insert);

        if (do_bump)
        begin
            tgt_idx = found_idx_reg;
        end
        else if (do_evict)
        begin
            tgt_idx = vic_idx_reg;
        end
        else
        begin
            tgt_idx = free_idx_reg;
        end

        wr_entry.key   = req_q_reg.key;
        wr_entry.value = is_get ? found_val_reg : req_q_reg.data_in;
        if (do_bump)
        begin
            wr_entry.count = (found_cnt_reg == COUNT_MAX) ? found_cnt_reg
                                                          : found_cnt_reg + 1'b1;
        end
        else
        begin
            wr_entry.count = COUNT_BITS'(1);
        end

        valid_next = valid_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (wr_en)
            begin
                if (tgt_idx == IDX_W'(i))
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i])
                begin
                    if (do_bump)
                    begin
                        if (rank_reg[i] < found_rank_reg)
                        begin
                            rank_next[i] = rank_reg[i] + 1'b1;
                        end
                    end
                    else if (do_evict)
                    begin
                        if (rank_reg[i] <= vic_rank_reg)
                        begin
                            rank_next[i] = rank_reg[i] + 1'b1;
                        end
                    end
                    else
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
            end
        end
        if (wr_en && do_insert)
        begin
            valid_next[tgt_idx] = 1'b1;
        end

        rsp_next.hit         = do_bump;
        rsp_next.data_out    = (is_get && found_reg) ? found_val_reg : '0;
        rsp_next.evicted     = do_evict;
        rsp_next.evicted_key = do_evict ? vic_key_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= CFG_RESET;
            idx_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            vic_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            occ_reg        <= '0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            done_reg    <= (state_reg == ST_WRITE);
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                vic_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                occ_reg        <= '0;
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (is_match)
                begin
                    found_reg <= 1'b1;
                end
                if (is_vic)
                begin
                    vic_reg <= 1'b1;
                end
                if (is_free)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cmp_vld_reg && cur_valid)
                begin
                    occ_reg <= occ_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg;
        rsp_reg     <= rsp_next;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
        if (accept)
        begin
            req_q_reg <= req;
        end
        if (is_match)
        begin
            found_idx_reg  <= cmp_idx_reg;
            found_rank_reg <= cur_rank;
            found_val_reg  <= rd_entry.value;
            found_cnt_reg  <= rd_entry.count;
        end
        if (is_vic)
        begin
            vic_idx_reg  <= cmp_idx_reg;
            vic_rank_reg <= cur_rank;
            vic_cnt_reg  <= rd_entry.count;
            vic_key_reg  <= rd_entry.key;
        end
        if (is_free)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WRITE))
        else $error("result strobe without a write-back cycle");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.evicted) |-> !rsp.hit)
        else $error("eviction reported on a hit");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && do_insert && !do_evict) |-> free_found_reg)
        else $error("insert without eviction found no free slot");

    a_insert_new: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && do_insert && !do_evict) |=> valid_reg[$past(tgt_idx)])
        else $error("inserted entry not marked valid");
`endif

endmodule

### rtl/lfu_ram.sv
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### verif/tb_lfu_cache_table_unit.sv
`timescale 1ns / 1ps

module tb_lfu_cache_table_unit;
    import lfu_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = CAPACITY + 4;
    localparam int POOL_SIZE     = 40;
    localparam int SAT_GETS      = 8;

    class lfu_shadow_cache;
        bit                    slot_used  [CAPACITY];
        logic [KEY_W-1:0]      slot_key   [CAPACITY];
        logic [DATA_W-1:0]     slot_value [CAPACITY];
        logic [COUNT_BITS-1:0] slot_count [CAPACITY];
        int unsigned           slot_age   [CAPACITY];
        logic [CFG_W-1:0]      entry_limit;
        lfu_rsp_t              expected_rsp [$];
        int                    mismatches;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i]  = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_count[i] = '0;
                slot_age[i]   = 0;
            end
            entry_limit = CFG_RESET;
            mismatches  = 0;
        endfunction

        // promote slot s to most recent; older ones keep their age when it was present
        function void make_newest(int s, bit present);
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (i != s && slot_used[i] && (!present || slot_age[i] < slot_age[s]))
                    slot_age[i]++;
            end
            slot_age[s] = 0;
        endfunction

        function void touch(int s);
            if (slot_count[s] != {COUNT_BITS{1'b1}})
                slot_count[s]++;
            make_newest(s, 1'b1);
        endfunction

        function void note_request(lfu_req_t r);
            lfu_rsp_t want;
            int       lim;
            int       hit_slot;
            int       free_slot;
            int       victim;
            int       used;
            want      = '0;
            lim       = (entry_limit > CAPACITY) ? CAPACITY : int'(entry_limit);
            hit_slot  = -1;
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (hit_slot < 0 && slot_used[i] && slot_key[i] == r.key)
                    hit_slot = i;
            end
            if (r.mode == MODE_GET)
            begin
                if (hit_slot >= 0)
                begin
                    want.hit      = 1'b1;
                    want.data_out = slot_value[hit_slot];
                    touch(hit_slot);
                end
            end
            else if (lim != 0)
            begin
                if (hit_slot >= 0)
                begin
                    want.hit             = 1'b1;
                    slot_value[hit_slot] = r.data_in;
                    touch(hit_slot);
                end
                else
                begin
                    used      = 0;
                    free_slot = -1;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (slot_used[i])
                            used++;
                        else if (free_slot < 0)
                            free_slot = i;
                    end
                    if (used >= lim)
                    begin
                        victim = -1;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (slot_used[i] && (victim < 0 ||
                                slot_count[i] < slot_count[victim] ||
                                (slot_count[i] == slot_count[victim] &&
                                 slot_age[i] > slot_age[victim])))
                                victim = i;
                        end
                        if (victim >= 0)
                        begin
                            want.evicted     = 1'b1;
                            want.evicted_key = slot_key[victim];
                            for (int i = 0; i < CAPACITY; i++)
                            begin
                                if (slot_used[i] && slot_age[i] > slot_age[victim])
                                    slot_age[i]--;
                            end
                            slot_used[victim] = 1'b0;
                            free_slot         = victim;
                        end
                    end
                    if (free_slot >= 0)
                    begin
                        slot_used[free_slot]  = 1'b1;
                        slot_key[free_slot]   = r.key;
                        slot_value[free_slot] = r.data_in;
                        slot_count[free_slot] = COUNT_BITS'(1);
                        make_newest(free_slot, 1'b0);
                    end
                end
            end
            expected_rsp.push_back(want);
        endfunction

        function void check_response(lfu_rsp_t got);
            lfu_rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected rsp hit=%0b data_out=%h ",
                             $realtime, got.hit, got.data_out,
                             "evicted=%0b evicted_key=%h",
                             got.evicted, got.evicted_key);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.hit !== want.hit || got.data_out !== want.data_out ||
                got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: bad rsp exp hit=%0b data_out=%h evicted=%0b key=%h",
                             $realtime, want.hit, want.data_out, want.evicted,
                             want.evicted_key,
                             " | got hit=%0b data_out=%h evicted=%0b key=%h",
                             got.hit, got.data_out, got.evicted, got.evicted_key);
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    lfu_req_t         req       = '0;
    logic             done;
    lfu_rsp_t         rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    lfu_shadow_cache  sb = new();
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               no_idle = 1'b0;
    int               stall_cycles = 0;

    lfu_cache_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_response(rsp);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("lfu_cache_table_unit: mismatch");
            $finish;
        end
    end

    task automatic issue(input logic m, input logic [KEY_W-1:0] k,
                         input logic [DATA_W-1:0] d);
        lfu_req_t r;
        int       gap;
        r.mode    = m;
        r.key     = k;
        r.data_in = d;
        gap       = 0;
        if (!no_idle && $urandom_range(99) < 10)
            gap = $urandom_range(1, 24);
        if (gap > 0)
        begin
            // hold start low until the block is not busy, then for a random gap while it is ready
            start <= 1'b0;
            do
                @(posedge clk);
            while (busy);
            repeat (gap - 1) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] v);
        drain();
        if (!no_idle && $urandom_range(99) < 30)
            repeat ($urandom_range(1, 6)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.entry_limit = v;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] v, input int n, input bit quiet);
        int               lim;
        int               span;
        int               base;
        logic             m;
        logic [KEY_W-1:0] k;
        no_idle = quiet;
        set_limit(v);
        lim  = (v > CAPACITY) ? CAPACITY : int'(v);
        span = lim + 4;
        base = $urandom_range(POOL_SIZE - span);
        repeat (n)
        begin
            m = 1'($urandom_range(1));
            if ($urandom_range(99) < 85)
                k = key_pool[base + $urandom_range(span - 1)];
            else
                k = $urandom;
            issue(m, k, $urandom);
        end
    endtask

    initial
    begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: two-entry cache, eviction by count and by age
        set_limit(CFG_W'(2));
        issue(MODE_GET, 32'h0000_0000, 32'hffff_ffff);
        issue(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
        issue(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
        issue(MODE_GET, 32'h8000_0000, 32'h0000_0000);
        issue(MODE_PUT, 32'h7fff_ffff, 32'h1234_5678);
        issue(MODE_GET, 32'h7fff_ffff, 32'hffff_ffff);
        issue(MODE_PUT, 32'hffff_ffff, 32'h0000_0000);
        issue(MODE_PUT, 32'h0000_0000, 32'hffff_ffff);
        issue(MODE_PUT, 32'h0000_0001, 32'h5555_aaaa);
        issue(MODE_GET, 32'h0000_0001, 32'h0000_0000);
        issue(MODE_GET, 32'h0000_0001, 32'h0000_0000);
        issue(MODE_PUT, 32'h0000_0002, 32'haaaa_5555);
        issue(MODE_GET, 32'h7fff_ffff, 32'h0000_0000);
        issue(MODE_GET, 32'h0000_0003, 32'hdead_beef);

        // disabled storage: puts do nothing, gets of stored keys still hit
        set_limit(CFG_W'(0));
        issue(MODE_PUT, 32'h0000_0001, 32'h0bad_0bad);
        issue(MODE_PUT, 32'h0000_0009, 32'h0bad_0bad);
        issue(MODE_GET, 32'h0000_0001, 32'h0000_0000);
        issue(MODE_GET, 32'h0000_0009, 32'h0000_0000);

        // raise one count well above the rest, then make sure it is not chosen as victim
        no_idle = 1'b1;
        set_limit(CFG_W'(2));
        issue(MODE_PUT, 32'h5a5a_0001, 32'h0000_0011);
        repeat (SAT_GETS)
            issue(MODE_GET, 32'h5a5a_0001, $urandom);
        issue(MODE_PUT, 32'h5a5a_0002, 32'h0000_0022);
        issue(MODE_PUT, 32'h5a5a_0001, 32'h0000_0033);
        issue(MODE_PUT, 32'h5a5a_0003, 32'h0000_0044);
        issue(MODE_GET, 32'h5a5a_0001, 32'h0000_0000);
        issue(MODE_GET, 32'h5a5a_0002, 32'h0000_0000);

        run_phase(CFG_W'(31), 70, 1'b0);
        run_phase(CFG_W'(3),  60, 1'b0);
        run_phase(CFG_W'(16), 70, 1'b1);
        run_phase(CFG_W'(1),  50, 1'b0);
        run_phase(CFG_W'(0),  40, 1'b0);
        run_phase(CFG_W'(8),  70, 1'b0);
        run_phase(CFG_W'(17), 60, 1'b0);
        run_phase(CFG_W'(16), 60, 1'b0);

        drain();
        if (sb.mismatches == 0 && sb.expected_rsp.size() == 0)
            $display("lfu_cache_table_unit: match");
        else
            $display("lfu_cache_table_unit: mismatch");
        $finish;
    end

endmodule
